>>> rtl/core/ptc_pkg.sv
// Shared types, register map, op codes and width helpers for the four-channel PWM timer.
// No dependencies; every other file of the block imports this package.
package ptc_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int NUM_CHANNELS = 4;
  localparam int NUM_CMP      = 4;
  localparam int PSC_WIDTH    = 16;
  localparam int DATA_WIDTH   = 16;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [PSC_WIDTH-1:0]   psc_t;
  typedef logic [DATA_WIDTH-1:0]  data_t;
  typedef logic [1:0]             op_t;
  typedef logic [3:0]             addr_t;
  typedef logic [3:0]             pwm_t;
  typedef logic [2:0]             mode_t;

  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam addr_t REG_CTRL   = 4'd0;
  localparam addr_t REG_IRQEN  = 4'd1;
  localparam addr_t REG_STATUS = 4'd2;
  localparam addr_t REG_EVENT  = 4'd3;
  localparam addr_t REG_MODE0  = 4'd4;
  localparam addr_t REG_MODE1  = 4'd5;
  localparam addr_t REG_OUTEN  = 4'd6;
  localparam addr_t REG_COUNT  = 4'd7;
  localparam addr_t REG_PRESC  = 4'd8;
  localparam addr_t REG_RELOAD = 4'd9;
  localparam addr_t REG_CMP0   = 4'd10;
  localparam addr_t REG_CMP1   = 4'd11;
  localparam addr_t REG_CMP2   = 4'd12;
  localparam addr_t REG_CMP3   = 4'd13;

  localparam mode_t MODE_FORCE = 3'd5;
  localparam mode_t MODE_PWM1  = 3'd6;
  localparam mode_t MODE_PWM2  = 3'd7;

  // Channel setup seen by the output stage.
  typedef struct packed {
    logic [1:0][DATA_WIDTH-1:0] modes;
    data_t                      out_en;
  } pwm_cfg_t;

  typedef logic [NUM_CMP-1:0][COUNT_WIDTH-1:0] cmp_arr_t;

  // Fit a bus word into the counter width (zero-extend or truncate).
  function automatic cnt_t fit_cnt(input data_t d);
    logic [31:0] w;
    w = 32'(d);
    return w[COUNT_WIDTH-1:0];
  endfunction

  // Fit a counter-width value onto the bus (zero-extend or truncate).
  function automatic data_t cnt_to_data(input cnt_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[DATA_WIDTH-1:0];
  endfunction

endpackage

>>> rtl/core/ptc_if.sv
// Valid/ready channel interfaces for the PWM timer: request items in, result items out.
// Depends on ptc_pkg for the payload types.
interface ptc_in_if import ptc_pkg::*;;
  logic  valid;
  logic  ready;
  op_t   op;
  addr_t reg_addr;
  data_t write_data;

  modport source (output valid, output op, output reg_addr, output write_data, input ready);
  modport sink   (input valid, input op, input reg_addr, input write_data, output ready);
endinterface

interface ptc_out_if import ptc_pkg::*;;
  logic  valid;
  logic  ready;
  data_t read_data;
  pwm_t  pwm_outputs;
  logic  irq_request;

  modport source (output valid, output read_data, output pwm_outputs, output irq_request,
                  input ready);
  modport sink   (input valid, input read_data, input pwm_outputs, input irq_request,
                  output ready);
endinterface

>>> rtl/core/ptc_pwm.sv
// Compare and output stage: derives the four PWM pin levels from count, compares and modes.
// Depends on ptc_pkg.
module ptc_pwm import ptc_pkg::*; (
  input  cnt_t     count,
  input  cmp_arr_t cmp,
  input  pwm_cfg_t cfg,
  output pwm_t     pwm
);

  always_comb begin
    mode_t mode;
    logic  below;
    logic  ref_lvl;
    pwm = '0;
    for (int c = 0; c < 4; c++) begin
      mode    = cfg.modes[c / 2][((c % 2) * 8 + 4) +: 3];
      below   = count < cmp[c];
      unique case (mode)
        MODE_PWM1:  ref_lvl = below;
        MODE_PWM2:  ref_lvl = !below;
        MODE_FORCE: ref_lvl = 1'b1;
        default:    ref_lvl = 1'b0;
      endcase
      // Disabled channel drives low; polarity flips the reference.
      if (c < NUM_CHANNELS && cfg.out_en[4 * c]) begin
        pwm[c] = ref_lvl ^ cfg.out_en[4 * c + 1];
      end
    end
  end

endmodule

>>> rtl/core/pwm_timer_four_channel_top.sv
// Top level of the four-channel PWM timer: input register, timer state, result register.
// Depends on ptc_pkg, ptc_in_if / ptc_out_if and ptc_pwm.
//
// Usage:
//   in_ch  carries one item per handshake: a clock tick, a register write or a
//          register read (op, reg_addr, write_data).
//   out_ch returns exactly one item for each input item, in order: read_data
//          (zero unless the item was a read), the PWM pin levels and the
//          interrupt request, all as they stand after that item.
//   Path:  an accepted item sits in the input register, is then loaded into
//          the result register and is offered on out_ch from then on.
//   Throughput: one item per cycle, sustained while out_ch is ready. The timer state is updated by
//          a single pass of short logic (16-bit increment and compare, then the
//          channel compares), so nothing limits the rate below one per cycle.
//   Reset (rst_n low at a clock edge): timer stopped, counters and prescalers
//          zero, reload all ones, compares, modes and enables zero, update flag
//          and interrupt enable clear, both pipeline registers empty.
//   Stall: when out_ch is not ready the result register holds its item; a
//          full input register then holds too and in_ch.ready drops until the
//          result register drains. No item is lost or repeated.
module pwm_timer_four_channel_top import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ptc_in_if.sink    in_ch,
  ptc_out_if.source out_ch
);

  // Input register
  logic  s1_valid_r;
  op_t   s1_op_r;
  addr_t s1_addr_r;
  data_t s1_data_r;

  // Result register
  logic  out_valid_r;
  data_t out_rdata_r;
  pwm_t  out_pwm_r;
  logic  out_irq_r;

  // Timer state
  cnt_t     main_count_r,   main_count_nxt;
  psc_t     psc_count_r,    psc_count_nxt;
  psc_t     psc_active_r,   psc_active_nxt;
  psc_t     psc_buf_r,      psc_buf_nxt;
  cnt_t     reload_r,       reload_nxt;
  cmp_arr_t cmp_r,          cmp_nxt;
  pwm_cfg_t pwm_cfg_r,      pwm_cfg_nxt;
  logic     run_r,          run_nxt;
  logic     irq_en_r,       irq_en_nxt;
  logic     upd_flag_r,     upd_flag_nxt;

  logic  out_free;
  logic  s1_go;
  data_t rdata;
  pwm_t  pwm_lvl;
  logic  [1:0] cmp_idx;

  // Result register can take a new item when empty or draining this cycle.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  assign cmp_idx = 2'(s1_addr_r - REG_CMP0);

  // Next timer state for the item in the input register.
  always_comb begin
    main_count_nxt = main_count_r;
    psc_count_nxt  = psc_count_r;
    psc_active_nxt = psc_active_r;
    psc_buf_nxt    = psc_buf_r;
    reload_nxt     = reload_r;
    cmp_nxt        = cmp_r;
    pwm_cfg_nxt    = pwm_cfg_r;
    run_nxt        = run_r;
    irq_en_nxt     = irq_en_r;
    upd_flag_nxt   = upd_flag_r;
    if (s1_go) begin
      unique case (s1_op_r)
        OP_TICK: begin
          if (run_r) begin
            if (psc_count_r >= psc_active_r) begin
              // Prescaler wrap advances the main counter.
              psc_count_nxt = '0;
              if (main_count_r >= reload_r) begin
                main_count_nxt = '0;
                upd_flag_nxt   = 1'b1;
                psc_active_nxt = psc_buf_r;
              end else begin
                main_count_nxt = main_count_r + COUNT_WIDTH'(1);
              end
            end else begin
              psc_count_nxt = psc_count_r + PSC_WIDTH'(1);
            end
          end
        end
        OP_WRITE: begin
          unique case (s1_addr_r)
            REG_CTRL:   run_nxt    = s1_data_r[0];
            REG_IRQEN:  irq_en_nxt = s1_data_r[0];
            REG_STATUS: begin
              // Write zero to clear; a one leaves the flag alone.
              if (!s1_data_r[0]) upd_flag_nxt = 1'b0;
            end
            REG_EVENT: begin
              if (s1_data_r[0]) begin
                main_count_nxt = '0;
                psc_count_nxt  = '0;
                psc_active_nxt = psc_buf_r;
                upd_flag_nxt   = 1'b1;
              end
            end
            REG_MODE0:  pwm_cfg_nxt.modes[0] = s1_data_r;
            REG_MODE1:  pwm_cfg_nxt.modes[1] = s1_data_r;
            REG_OUTEN:  pwm_cfg_nxt.out_en   = s1_data_r;
            REG_COUNT:  main_count_nxt = fit_cnt(s1_data_r);
            REG_PRESC:  psc_buf_nxt    = s1_data_r;
            REG_RELOAD: reload_nxt     = fit_cnt(s1_data_r);
            REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
              cmp_nxt[cmp_idx] = fit_cnt(s1_data_r);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Read mux on the current state; reads change nothing.
  always_comb begin
    rdata = '0;
    if (s1_op_r == OP_READ) begin
      unique case (s1_addr_r)
        REG_CTRL:   rdata = DATA_WIDTH'(run_r);
        REG_IRQEN:  rdata = DATA_WIDTH'(irq_en_r);
        REG_STATUS: rdata = DATA_WIDTH'(upd_flag_r);
        REG_MODE0:  rdata = pwm_cfg_r.modes[0];
        REG_MODE1:  rdata = pwm_cfg_r.modes[1];
        REG_OUTEN:  rdata = pwm_cfg_r.out_en;
        REG_COUNT:  rdata = cnt_to_data(main_count_r);
        REG_PRESC:  rdata = psc_buf_r;
        REG_RELOAD: rdata = cnt_to_data(reload_r);
        REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
          rdata = cnt_to_data(cmp_r[cmp_idx]);
        default:    rdata = '0;
      endcase
    end
  end

  // Pin levels as they stand after this item.
  ptc_pwm u_pwm (
    .count (main_count_nxt),
    .cmp   (cmp_nxt),
    .cfg   (pwm_cfg_nxt),
    .pwm   (pwm_lvl)
  );

  // Input register: load on accept, drop when passed on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r   <= in_ch.op;
      s1_addr_r <= in_ch.reg_addr;
      s1_data_r <= in_ch.write_data;
    end
  end

  // Timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_count_r <= '0;
      psc_count_r  <= '0;
      psc_active_r <= '0;
      psc_buf_r    <= '0;
      reload_r     <= '1;
      cmp_r        <= '0;
      pwm_cfg_r    <= '0;
      run_r        <= 1'b0;
      irq_en_r     <= 1'b0;
      upd_flag_r   <= 1'b0;
    end else begin
      main_count_r <= main_count_nxt;
      psc_count_r  <= psc_count_nxt;
      psc_active_r <= psc_active_nxt;
      psc_buf_r    <= psc_buf_nxt;
      reload_r     <= reload_nxt;
      cmp_r        <= cmp_nxt;
      pwm_cfg_r    <= pwm_cfg_nxt;
      run_r        <= run_nxt;
      irq_en_r     <= irq_en_nxt;
      upd_flag_r   <= upd_flag_nxt;
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_rdata_r <= rdata;
      out_pwm_r   <= pwm_lvl;
      out_irq_r   <= upd_flag_nxt && irq_en_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_rdata_r;
  assign out_ch.pwm_outputs = out_pwm_r;
  assign out_ch.irq_request = out_irq_r;

  // A processed item always shows up in the result register next cycle.
  a_item_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("processed item did not reach result register");

  // Only reads return data.
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_op_r != OP_READ) |=> (out_rdata_r == '0))
    else $error("nonzero read_data on a non-read item");

  // A stopped timer ignores ticks.
  a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_op_r == OP_TICK && !run_r) |=> $stable(main_count_r))
    else $error("counter moved while stopped");

  // The interrupt request tracks flag and enable after the item.
  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> (out_irq_r == (upd_flag_r && irq_en_r)))
    else $error("irq_request out of step with flag and enable");

endmodule

>>> test/pwm_timer_four_channel_top_test.sv
// Self-checking testbench for pwm_timer_four_channel_top: ticks, register writes and reads
// go in, and every result is checked against an in-bench timer predictor.
// Depends on ptc_pkg and the ptc_in_if / ptc_out_if channel interfaces.
`timescale 1ns / 100ps

module pwm_timer_four_channel_top_test;
  import ptc_pkg::*;

  // Op code with no action, and the two unmapped register numbers.
  localparam op_t   OP_NONE         = 2'd3;
  localparam addr_t REG_UNMAPPED_LO = 4'd14;
  localparam addr_t REG_UNMAPPED_HI = 4'd15;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_PHASES   = 4;

  typedef struct packed {
    op_t   op;
    addr_t reg_addr;
    data_t write_data;
  } timer_req_t;

  typedef struct packed {
    data_t read_data;
    pwm_t  pwm_outputs;
    logic  irq_request;
  } timer_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptc_in_if  req_ch ();
  ptc_out_if resp_ch ();

  pwm_timer_four_channel_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (resp_ch)
  );

  always #5 clk = ~clk;

  // Items waiting to be offered, and results owed by the block, oldest first.
  timer_req_t  pending_reqs[$];
  timer_resp_t owed_results[$];

  // Idle and stall rates of the current phase, in percent.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int fail_count   = 0;
  int cycle_count  = 0;

  // Long receiver hold-off: requested once by the stimulus, counted down here.
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // Timer state as the predictor sees it, starting from the reset values.
  cnt_t  tmr_count      = '0;
  psc_t  psc_count      = '0;
  psc_t  psc_active     = '0;
  psc_t  psc_buffered   = '0;
  cnt_t  tmr_reload     = '1;
  cnt_t  tmr_compare[4] = '{default: '0};
  data_t chan_mode[2]   = '{default: '0};
  data_t out_enable     = '0;
  bit    run_on         = 1'b0;
  bit    irq_on         = 1'b0;
  bit    update_pending = 1'b0;

  // Apply one item to the predicted timer and return the result it causes.
  function automatic timer_resp_t step_timer(timer_req_t r);
    timer_resp_t res;
    mode_t       mode;
    bit          below;
    bit          active_lvl;
    res = '0;
    case (r.op)
      OP_TICK: begin
        // Stopped timer ignores ticks; a counter above its limit wraps on the next advance.
        if (run_on) begin
          if (psc_count >= psc_active) begin
            psc_count = '0;
            if (tmr_count >= tmr_reload) begin
              tmr_count      = '0;
              update_pending = 1'b1;
              psc_active     = psc_buffered;
            end else begin
              tmr_count = tmr_count + cnt_t'(1);
            end
          end else begin
            psc_count = psc_count + psc_t'(1);
          end
        end
      end
      OP_WRITE: begin
        case (r.reg_addr)
          REG_CTRL:   run_on = r.write_data[0];
          REG_IRQEN:  irq_on = r.write_data[0];
          // Writing zero clears the flag; writing one leaves it alone.
          REG_STATUS: if (!r.write_data[0]) update_pending = 1'b0;
          REG_EVENT: begin
            if (r.write_data[0]) begin
              tmr_count      = '0;
              psc_count      = '0;
              psc_active     = psc_buffered;
              update_pending = 1'b1;
            end
          end
          REG_MODE0:  chan_mode[0] = r.write_data;
          REG_MODE1:  chan_mode[1] = r.write_data;
          REG_OUTEN:  out_enable   = r.write_data;
          REG_COUNT:  tmr_count    = r.write_data;
          REG_PRESC:  psc_buffered = r.write_data;
          REG_RELOAD: tmr_reload   = r.write_data;
          REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
            tmr_compare[2'(r.reg_addr - REG_CMP0)] = r.write_data;
          default: ;
        endcase
      end
      OP_READ: begin
        case (r.reg_addr)
          REG_CTRL:   res.read_data = data_t'(run_on);
          REG_IRQEN:  res.read_data = data_t'(irq_on);
          REG_STATUS: res.read_data = data_t'(update_pending);
          REG_MODE0:  res.read_data = chan_mode[0];
          REG_MODE1:  res.read_data = chan_mode[1];
          REG_OUTEN:  res.read_data = out_enable;
          REG_COUNT:  res.read_data = tmr_count;
          REG_PRESC:  res.read_data = psc_buffered;
          REG_RELOAD: res.read_data = tmr_reload;
          REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
            res.read_data = tmr_compare[2'(r.reg_addr - REG_CMP0)];
          default:    res.read_data = '0;
        endcase
      end
      default: ;
    endcase

    // Pin levels after the item: mode picks the reference, polarity inverts it,
    // a disabled channel stays low.
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      mode  = mode_t'(chan_mode[c / 2] >> (4 + 8 * (c % 2)));
      below = tmr_count < tmr_compare[c];
      case (mode)
        MODE_PWM1:  active_lvl = below;
        MODE_PWM2:  active_lvl = !below;
        MODE_FORCE: active_lvl = 1'b1;
        default:    active_lvl = 1'b0;
      endcase
      if (out_enable[4 * c]) res.pwm_outputs[c] = active_lvl ^ out_enable[4 * c + 1];
    end
    res.irq_request = update_pending && irq_on;
    return res;
  endfunction

  function automatic void add_req(op_t op, addr_t addr, data_t data);
    pending_reqs.push_back('{op: op, reg_addr: addr, write_data: data});
  endfunction

  // Random item, shaped so the timer keeps running with short periods and
  // compares that land inside them; now and then a full-width value.
  function automatic timer_req_t random_req();
    timer_req_t r;
    int         roll;
    roll         = $urandom_range(99);
    r.reg_addr   = addr_t'($urandom_range(15));
    r.write_data = data_t'($urandom);
    if (roll < 60) begin
      r.op = OP_TICK;
    end else if (roll < 78) begin
      r.op = OP_WRITE;
      case (r.reg_addr)
        REG_CTRL:   r.write_data[0] = ($urandom_range(9) != 0);
        REG_EVENT:  r.write_data[0] = ($urandom_range(3) == 0);
        REG_RELOAD: if ($urandom_range(3) != 0) r.write_data = data_t'($urandom_range(12));
        REG_PRESC:  if ($urandom_range(3) != 0) r.write_data = data_t'($urandom_range(3));
        REG_COUNT:  if ($urandom_range(9) < 7) r.write_data = data_t'($urandom_range(15));
        REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
          if ($urandom_range(3) != 0) r.write_data = data_t'($urandom_range(14));
        REG_MODE0, REG_MODE1: begin
          // Favor the modes that do something; keep some fully random words.
          if ($urandom_range(3) != 0) begin
            r.write_data[6:4]   = 3'($urandom_range(7, 4));
            r.write_data[14:12] = 3'($urandom_range(7, 4));
          end
        end
        default: ;
      endcase
    end else if (roll < 96) begin
      r.op = OP_READ;
    end else begin
      r.op = OP_NONE;
    end
    return r;
  endfunction

  // Driver: predict each item as it is accepted, then offer the next one
  // unless this cycle is to be idle. valid gets at most one assignment per edge.
  timer_req_t on_bus;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) owed_results.push_back(step_timer(on_bus));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_bus = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.op         <= on_bus.op;
          req_ch.reg_addr   <= on_bus.reg_addr;
          req_ch.write_data <= on_bus.write_data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest owed one, then
  // choose ready for the next edge.
  always @(posedge clk) begin
    timer_resp_t want;
    if (!rst_n) begin
      resp_ch.ready <= 1'b0;
    end else begin
      if (resp_ch.valid && resp_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("result item with nothing owed");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (resp_ch.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, resp_ch.read_data);
            fail_count++;
          end
          if (resp_ch.pwm_outputs !== want.pwm_outputs) begin
            $error("pwm_outputs: expected %b, got %b", want.pwm_outputs, resp_ch.pwm_outputs);
            fail_count++;
          end
          if (resp_ch.irq_request !== want.irq_request) begin
            $error("irq_request: expected %b, got %b", want.irq_request, resp_ch.irq_request);
            fail_count++;
          end
        end
      end
      resp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long hold-off of the receiver, armed once by the stimulus.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus: directed items, then four phases of random items with
  // different idle and stall rates.
  initial begin
    automatic int tx_pct[NUM_PHASES]  = '{0, 58, 0, 32};
    automatic int rx_pct[NUM_PHASES]  = '{0, 0, 58, 32};
    automatic int n_items[NUM_PHASES] = '{150, 135, 135, 130};

    // Hold all inputs known until reset takes over.
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_TICK;
    req_ch.reg_addr   = REG_CTRL;
    req_ch.write_data = '0;
    resp_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: reset values, a tick while stopped, the dead op code,
    // every compare mode and polarity, event and status bits, a counter above
    // reload, the unmapped registers.
    add_req(OP_READ,  REG_RELOAD,      16'h0000);
    add_req(OP_TICK,  REG_CTRL,        16'hFFFF);
    add_req(OP_NONE,  REG_UNMAPPED_HI, 16'hFFFF);
    add_req(OP_WRITE, REG_MODE0,       16'h7060);  // ch0 below-compare, ch1 at-or-above
    add_req(OP_WRITE, REG_MODE1,       16'h4050);  // ch2 forced active, ch3 inactive
    add_req(OP_WRITE, REG_OUTEN,       16'h1313);  // all enabled, ch0 and ch2 inverted
    add_req(OP_WRITE, REG_CMP0,        16'h0003);
    add_req(OP_WRITE, REG_CMP1,        16'hFFFF);
    add_req(OP_WRITE, REG_CMP3,        16'h8000);
    add_req(OP_WRITE, REG_RELOAD,      16'h0005);
    add_req(OP_WRITE, REG_PRESC,       16'h0001);
    add_req(OP_WRITE, REG_EVENT,       16'hFFFE);  // bit 0 clear: no update
    add_req(OP_WRITE, REG_EVENT,       16'h0001);  // update generate
    add_req(OP_WRITE, REG_IRQEN,       16'h0001);
    add_req(OP_WRITE, REG_STATUS,      16'hFFFF);  // a one keeps the flag
    add_req(OP_READ,  REG_STATUS,      16'h0000);
    add_req(OP_WRITE, REG_STATUS,      16'h0000);
    add_req(OP_WRITE, REG_COUNT,       16'hFFFF);  // above reload: wraps on next advance
    add_req(OP_WRITE, REG_CTRL,        16'h0001);
    repeat (3) add_req(OP_TICK, REG_CTRL, 16'h0000);
    add_req(OP_WRITE, REG_UNMAPPED_LO, 16'hFFFF);
    add_req(OP_READ,  REG_UNMAPPED_HI, 16'h0000);
    add_req(OP_READ,  REG_EVENT,       16'h0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      add_req(OP_WRITE, REG_CTRL, 16'h0001);
      repeat (n_items[p]) pending_reqs.push_back(random_req());
      // First phase: stop the receiver for a long stretch while items keep coming.
      if (p == 0) hold_req = 1'b1;
      while (pending_reqs.size() != 0 || req_ch.valid || owed_results.size() != 0)
        @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ptc_pkg.sv
rtl/core/ptc_if.sv
rtl/core/ptc_pwm.sv
rtl/core/pwm_timer_four_channel_top.sv
test/pwm_timer_four_channel_top_test.sv
